// File: sv/iir_direct_form_filter_unit_assert.svh
// Assertion macros shared by the checker of the IIR filter unit.
`ifndef IIR_DIRECT_FORM_FILTER_UNIT_ASSERT_SVH
`define IIR_DIRECT_FORM_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define IIRDF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define IIRDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/iirdf_pkg.sv
// Shared widths, types and register codes of the direct form I IIR filter.
package iirdf_pkg;

	// Filter order, clamped to the available history.
	localparam int FILTER_ORDER = 2;
	localparam int HIST_DEPTH   = 3;
	localparam int ORDER_EFF    = (FILTER_ORDER < 1) ? 1 :
		((FILTER_ORDER > HIST_DEPTH) ? HIST_DEPTH : FILTER_ORDER);
	localparam int NUM_TAPS     = HIST_DEPTH + 1;

	// Datapath widths (coefficients Q3.14, samples 16-bit integers).
	localparam int SAMP_W    = 16;
	localparam int COEF_W    = 18;
	localparam int FRAC_BITS = 14;
	localparam int PROD_W    = COEF_W + SAMP_W;
	localparam int SUMX_W    = PROD_W + 2;
	localparam int PART_W    = SUMX_W + 1;
	localparam int ACC_W     = PART_W + 1;
	localparam int RND_W     = ACC_W - FRAC_BITS;

	// Distance from the last block start, saturating at the history depth.
	localparam int POS_W = 2;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(HIST_DEPTH);

	// Requests in flight between input and output ports: four stages plus the output.
	localparam int MAX_INFLIGHT = 5;
	localparam int CNT_W        = 3;

	localparam int CFG_IDX_W = 3;

	typedef logic signed [SAMP_W-1:0] samp_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam coef_t COEF_B0_RESET = COEF_W'(16384);

	// Coefficient register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_B0 = 3'd0,
		REG_COEF_B1 = 3'd1,
		REG_COEF_B2 = 3'd2,
		REG_COEF_B3 = 3'd3,
		REG_COEF_A1 = 3'd4,
		REG_COEF_A2 = 3'd5,
		REG_COEF_A3 = 3'd6
	} reg_idx_t;

	// Controls of one tap cell.
	typedef struct packed {
		logic load;     // new request accepted: shift the tap chain
		logic clear;    // block start: load zero instead of neighbor
		logic advance;  // stage 1 moves on: register the product
	} cell_ctl_t;

	// Feed-forward sum handed to the feedback section.
	typedef struct packed {
		logic              valid;
		logic [POS_W-1:0]  pos;
		logic [SUMX_W-1:0] sumx;  // signed
	} s3_req_t;

endpackage

// File: sv/iirdf_cell.sv
// One input tap cell: holds a delayed sample and forms its numerator product.
module iirdf_cell import iirdf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  samp_t     tap_in,
	input  coef_t     coef,
	output samp_t     tap_q,
	output prod_t     prod_s2
);

	// Tap register: takes the neighbor's sample on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (ctl.load) begin
			tap_q <= ctl.clear ? samp_t'(0) : tap_in;
		end
	end

	// Product of the tap with its coefficient
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			prod_s2 <= PROD_W'(coef) * PROD_W'(tap_q);
		end
	end

endmodule

// File: sv/iirdf_fb.sv
// Feedback section: output history, feedback products, rounding and output register.
module iirdf_fb import iirdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  s3_req_t req,
	output logic    req_ready,
	input  coef_t   coef_a [HIST_DEPTH],  // a1, a2, a3
	output logic    out_valid,
	input  logic    out_ready,
	output samp_t   out_data
);

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [RND_W-1:0] Y_MAX = RND_W'(2 ** (SAMP_W - 1) - 1);
	localparam logic signed [RND_W-1:0] Y_MIN = RND_W'(-(2 ** (SAMP_W - 1)));

	// Round half up from Q.14 and saturate to the sample range
	function automatic samp_t round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [RND_W-1:0] rnd;
		biased = acc + ROUND_HALF;
		rnd    = RND_W'(biased >>> FRAC_BITS);
		if (rnd > Y_MAX) begin
			return samp_t'(Y_MAX);
		end else if (rnd < Y_MIN) begin
			return samp_t'(Y_MIN);
		end
		return samp_t'(rnd);
	endfunction

	samp_t                    yh_q [HIST_DEPTH];
	logic                     v_s4;
	logic [POS_W-1:0]         pos_s4;
	logic signed [PART_W-1:0] part_s4;
	logic                     out_valid_q;
	samp_t                    out_q;

	logic                     fire4;
	logic                     load4;
	samp_t                    y2;
	samp_t                    y3;
	prod_t                    prod_a2;
	prod_t                    prod_a3;
	logic signed [PART_W-1:0] part_next;
	samp_t                    y1;
	prod_t                    prod_a1;
	logic signed [ACC_W-1:0]  acc;
	samp_t                    y_new;

	// Handshake of the feedback stage and the output register
	assign fire4     = v_s4 && (!out_valid_q || out_ready);
	assign req_ready = !v_s4 || fire4;
	assign load4     = req.valid && req_ready;

	// Older outputs: one step further back while the previous request is still in stage 4
	always_comb begin
		y2 = v_s4 ? yh_q[0] : yh_q[1];
		y3 = v_s4 ? yh_q[1] : yh_q[2];
		if (req.pos < POS_W'(2)) begin
			y2 = '0;
		end
		if (req.pos < POS_MAX) begin
			y3 = '0;
		end
	end

	assign prod_a2   = PROD_W'(coef_a[1]) * PROD_W'(y2);
	assign prod_a3   = PROD_W'(coef_a[2]) * PROD_W'(y3);
	assign part_next = PART_W'($signed(req.sumx)) - PART_W'(prod_a2) - PART_W'(prod_a3);

	// Recursion: latest output times a1 closes the loop combinationally within stage 4
	assign y1      = (pos_s4 != '0) ? yh_q[0] : samp_t'(0);
	assign prod_a1 = PROD_W'(coef_a[0]) * PROD_W'(y1);
	assign acc     = ACC_W'(part_s4) - ACC_W'(prod_a1);
	assign y_new   = round_sat(acc);

	// Stage 4 and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load4) begin
				v_s4 <= 1'b1;
			end else if (fire4) begin
				v_s4 <= 1'b0;
			end
			if (fire4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output history shifts on every produced sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST_DEPTH; k++) begin
				yh_q[k] <= '0;
			end
		end else if (fire4) begin
			yh_q[0] <= y_new;
			for (int k = 1; k < HIST_DEPTH; k++) begin
				yh_q[k] <= yh_q[k-1];
			end
		end
	end

	// Payload of stage 4 and of the output register
	always_ff @(posedge clk) begin
		if (load4) begin
			pos_s4  <= req.pos;
			part_s4 <= part_next;
		end
		if (fire4) begin
			out_q <= y_new;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: sv/iir_direct_form_filter_unit.sv
// Top level of the direct form I IIR filter unit.
// Takes one sample and gives one filtered sample per clock while m_tready is high,
// y = sum b_k*x[n-k] - sum a_k*y[n-k] with Q3.14 coefficients, rounded half up and
// saturated to 16 bits. A taken request moves through the tap register, the tap products,
// the feed-forward sum, the older-output products, then feedback into the output register.
// The one-sample rate is set by the feedback stage, where a1 times the previous output,
// the add, the rounding and the saturation complete combinationally within stage 4.
// A request with block_start set treats all earlier samples and outputs as zero.
// The user must write coefficients while the unit is idle (unenforced); no clearing pass.
module iir_direct_form_filter_unit import iirdf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [SAMP_W-1:0]    s_tdata,    // [15:0] sample_in
	input  logic [0:0]           s_tuser,    // [0] block_start
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [SAMP_W-1:0]    m_tdata,    // [15:0] sample_out
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_wdata
);

	coef_t coef_b_q [NUM_TAPS];
	coef_t coef_a_q [HIST_DEPTH];
	coef_t coef_b_use [NUM_TAPS];
	coef_t coef_a_use [HIST_DEPTH];

	logic                     v_s1;
	logic [POS_W-1:0]         pos_s1;
	logic                     v_s2;
	logic [POS_W-1:0]         pos_s2;
	logic                     v_s3;
	logic [POS_W-1:0]         pos_s3;
	logic signed [SUMX_W-1:0] sumx_s3;

	logic                     accept;
	logic                     adv1;
	logic                     adv2;
	logic                     adv3;
	logic                     fb_ready;
	samp_t                    tap [NUM_TAPS];
	prod_t                    prod [NUM_TAPS];
	logic signed [SUMX_W-1:0] sumx_next;
	s3_req_t                  req;
	samp_t                    out_data;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b_q[0] <= COEF_B0_RESET;
			for (int k = 1; k < NUM_TAPS; k++) begin
				coef_b_q[k] <= '0;
			end
			for (int k = 0; k < HIST_DEPTH; k++) begin
				coef_a_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COEF_B0: coef_b_q[0] <= cfg_wdata;
				REG_COEF_B1: coef_b_q[1] <= cfg_wdata;
				REG_COEF_B2: coef_b_q[2] <= cfg_wdata;
				REG_COEF_B3: coef_b_q[3] <= cfg_wdata;
				REG_COEF_A1: coef_a_q[0] <= cfg_wdata;
				REG_COEF_A2: coef_a_q[1] <= cfg_wdata;
				REG_COEF_A3: coef_a_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Taps above the filter order contribute nothing
	for (genvar k = 0; k < NUM_TAPS; k++) begin : g_b_use
		assign coef_b_use[k] = (k <= ORDER_EFF) ? coef_b_q[k] : coef_t'(0);
	end
	for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_a_use
		assign coef_a_use[k] = (k + 1 <= ORDER_EFF) ? coef_a_q[k] : coef_t'(0);
	end

	// Pipeline handshake, back to front
	assign adv3     = v_s3 && fb_ready;
	assign adv2     = v_s2 && (!v_s3 || adv3);
	assign adv1     = v_s1 && (!v_s2 || adv2);
	assign s_tready = !v_s1 || adv1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			pos_s1 <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			// distance from block start of the newest request
			if (accept) begin
				if (s_tuser[0]) begin
					pos_s1 <= '0;
				end else if (pos_s1 != POS_MAX) begin
					pos_s1 <= pos_s1 + POS_W'(1);
				end
			end
		end
	end

	// Chain of input tap cells; cell 0 holds the newest sample
	for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
		cell_ctl_t ctl;
		samp_t     tin;
		if (k == 0) begin : g_head
			assign tin = $signed(s_tdata);
		end else begin : g_body
			assign tin = tap[k-1];
		end
		assign ctl.load    = accept;
		assign ctl.clear   = (k != 0) && s_tuser[0];
		assign ctl.advance = adv1;
		iirdf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tap_in  (tin),
			.coef    (coef_b_use[k]),
			.tap_q   (tap[k]),
			.prod_s2 (prod[k])
		);
	end

	// Feed-forward sum of the tap products
	always_comb begin
		sumx_next = '0;
		for (int k = 0; k < NUM_TAPS; k++) begin
			sumx_next = sumx_next + SUMX_W'(prod[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pos_s2 <= pos_s1;
		end
		if (adv2) begin
			pos_s3  <= pos_s2;
			sumx_s3 <= sumx_next;
		end
	end

	assign req.valid = v_s3;
	assign req.pos   = pos_s3;
	assign req.sumx  = sumx_s3;

	iirdf_fb u_fb (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_ready (fb_ready),
		.coef_a    (coef_a_use),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = out_data;

endmodule

// File: sv/iirdf_checker.sv
// Port-level checker of the IIR filter unit, bound to the top level.
`include "iir_direct_form_filter_unit_assert.svh"

module iirdf_checker import iirdf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [SAMP_W-1:0] m_tdata
);

	logic [CNT_W-1:0] cnt_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	`IIRDF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output changed")
	`IIRDF_ASSERT_NOW(a_out_has_source, m_tvalid, cnt_q != '0, "output without a pending request")
	`IIRDF_ASSERT_NOW(a_inflight_bound, in_acc || out_acc || m_tvalid, cnt_q <= CNT_W'(MAX_INFLIGHT), "too many requests in flight")
	`IIRDF_ASSERT_NOW(a_idle_ready, cnt_q == '0, s_tready, "empty unit not ready")

endmodule

bind iir_direct_form_filter_unit iirdf_checker u_checker (.*);
